@@ design/dnsarp_pkg.sv @@
// shared types and constants for the dns answer record parser
package dnsarp_pkg;

   // parse phases, one-hot
   typedef enum logic [10:0] {
      PH_HEADER     = 11'b000_0000_0001,
      PH_QNAME_LEN  = 11'b000_0000_0010,
      PH_QNAME_SKIP = 11'b000_0000_0100,
      PH_QNAME_PTR  = 11'b000_0000_1000,
      PH_QFIXED     = 11'b000_0001_0000,
      PH_RNAME_LEN  = 11'b000_0010_0000,
      PH_RNAME_SKIP = 11'b000_0100_0000,
      PH_RNAME_PTR  = 11'b000_1000_0000,
      PH_RFIXED     = 11'b001_0000_0000,
      PH_RDATA      = 11'b010_0000_0000,
      PH_DONE       = 11'b100_0000_0000
   } phase_type;

   // result status codes
   localparam logic [2:0] ST_A        = 3'd0;
   localparam logic [2:0] ST_AAAA     = 3'd1;
   localparam logic [2:0] ST_FOLLOW   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;
   localparam logic [2:0] ST_DROP     = 3'd5;

   // record types
   localparam logic [15:0] RT_A     = 16'd1;
   localparam logic [15:0] RT_CNAME = 16'd5;
   localparam logic [15:0] RT_AAAA  = 16'd28;

   // packet layout
   localparam int unsigned HDR_LEN  = 12;
   localparam logic [15:0] RR_FIXED = 16'd10;
   localparam logic [15:0] Q_FIXED  = 16'd4;
   localparam logic [7:0]  PTR_MARK = 8'hC0;
   localparam logic [3:0]  RCODE_NXDOMAIN = 4'd3;
   localparam int unsigned CNAME_W  = 11;

   // register indexes
   localparam logic REG_EXPECTED_ID = 1'b0;
   localparam logic REG_QUERY_TYPE  = 1'b1;

endpackage

@@ design/dns_answer_record_parser.sv @@
// dns response parser: walks the answer records of a byte stream, one result per packet
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| packet_byte, last_byte
//  rsp     | out       | rsp_valid/rsp_stall| status, address_high/low, cname_offset
//  csr     | in        | apb write/read     | expected_id (0x0), query_type (0x4)
//
// one byte per cycle while req_stall is low: every parse step is one pass through the next-state logic
// the result is registered on the cycle after the last byte is taken
// req_stall is high only while a result is held and rsp_stall is high
// synchronous reset clears the parse state, the registers and the result valid
module dns_answer_record_parser #(
   parameter int unsigned MAX_PACKET = 1536
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_address_high,
   output logic [63:0] rsp_address_low,
   output logic [10:0] rsp_cname_offset,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned OFS_W = $clog2(MAX_PACKET + 2);
   localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_PACKET);
   localparam logic [OFS_W-1:0] OFS_HDR = OFS_W'(dnsarp_pkg::HDR_LEN);

   // configuration registers
   logic [15:0] expected_id_ff;
   logic        query_type_ff;
   logic        cfg_write;

   // parse state
   dnsarp_pkg::phase_type phase_ff, phase_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] answers_ff, answers_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] rdlen_ff, rdlen_in;
   logic        found_ff, found_in;
   logic [63:0] addr_hi_ff, addr_hi_in;
   logic [63:0] addr_lo_ff, addr_lo_in;
   logic        cname_seen_ff, cname_seen_in;
   logic [dnsarp_pkg::CNAME_W-1:0] cname_pos_ff, cname_pos_in;
   logic [2:0]  outcome_ff, outcome_in;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  status_ff, status_in;
   logic [63:0] res_hi_ff, res_hi_in;
   logic [63:0] res_lo_ff, res_lo_in;
   logic [dnsarp_pkg::CNAME_W-1:0] res_cname_ff, res_cname_in;

   // helpers
   logic        req_accept;
   logic        rsp_accept;
   logic        load_result;
   logic [15:0] remain_dec;
   logic [15:0] word_new;
   logic [15:0] fixed_idx;
   logic        record_end;
   logic        next_rec;
   logic [OFS_W:0] pos_plus;
   logic        is_ptr;

   // handshakes
   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign req_accept  = req_valid & ~req_stall;
   assign rsp_accept  = rsp_valid_ff & ~rsp_stall;
   assign load_result = req_accept & req_last_byte;

   assign remain_dec = remain_ff - 16'd1;
   assign word_new   = {hold_ff, req_packet_byte};
   assign fixed_idx  = dnsarp_pkg::RR_FIXED - remain_ff;
   assign pos_plus   = {1'b0, offset_ff} + {{OFS_W{1'b0}}, 1'b1};
   assign is_ptr     = (req_packet_byte & dnsarp_pkg::PTR_MARK) == dnsarp_pkg::PTR_MARK;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == dnsarp_pkg::REG_QUERY_TYPE) ?
                       {31'd0, query_type_ff} : {16'd0, expected_id_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 16'd0;
         query_type_ff  <= 1'b0;
      end else if (cfg_write) begin
         unique case (csr_paddr[2])
            dnsarp_pkg::REG_EXPECTED_ID: expected_id_ff <= csr_pwdata[15:0];
            dnsarp_pkg::REG_QUERY_TYPE:  query_type_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // per-byte parse step
   always_comb begin
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      remain_in     = remain_ff;
      answers_in    = answers_ff;
      hold_in       = hold_ff;
      rtype_in      = rtype_ff;
      rdlen_in      = rdlen_ff;
      found_in      = found_ff;
      addr_hi_in    = addr_hi_ff;
      addr_lo_in    = addr_lo_ff;
      cname_seen_in = cname_seen_ff;
      cname_pos_in  = cname_pos_ff;
      outcome_in    = outcome_ff;
      record_end    = 1'b0;
      next_rec      = 1'b0;

      unique case (phase_ff)
         // fixed header, byte position picks the field
         dnsarp_pkg::PH_HEADER: begin
            if (offset_ff == OFS_W'(0) || offset_ff == OFS_W'(6)) begin
               hold_in = req_packet_byte;
            end else if (offset_ff == OFS_W'(1)) begin
               hold_in = req_packet_byte;
               if (word_new != expected_id_ff) begin
                  phase_in   = dnsarp_pkg::PH_DONE;
                  outcome_in = dnsarp_pkg::ST_DROP;
               end
            end else if (offset_ff == OFS_W'(3)) begin
               if (req_packet_byte[3:0] == dnsarp_pkg::RCODE_NXDOMAIN) begin
                  phase_in   = dnsarp_pkg::PH_DONE;
                  outcome_in = dnsarp_pkg::ST_NOTFOUND;
               end else if (req_packet_byte[3:0] != 4'd0) begin
                  phase_in   = dnsarp_pkg::PH_DONE;
                  outcome_in = dnsarp_pkg::ST_ERROR;
               end
            end else if (offset_ff == OFS_W'(7)) begin
               answers_in = word_new;
            end else if (offset_ff == OFS_W'(dnsarp_pkg::HDR_LEN - 1)) begin
               phase_in = dnsarp_pkg::PH_QNAME_LEN;
            end
         end
         // question name: label length, pointer or terminator
         dnsarp_pkg::PH_QNAME_LEN: begin
            if (req_packet_byte == 8'd0) begin
               phase_in  = dnsarp_pkg::PH_QFIXED;
               remain_in = dnsarp_pkg::Q_FIXED;
            end else if (is_ptr) begin
               phase_in = dnsarp_pkg::PH_QNAME_PTR;
            end else begin
               remain_in = {8'd0, req_packet_byte};
               phase_in  = dnsarp_pkg::PH_QNAME_SKIP;
            end
         end
         dnsarp_pkg::PH_QNAME_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == 16'd0) phase_in = dnsarp_pkg::PH_QNAME_LEN;
         end
         dnsarp_pkg::PH_QNAME_PTR: begin
            phase_in  = dnsarp_pkg::PH_QFIXED;
            remain_in = dnsarp_pkg::Q_FIXED;
         end
         // question type and class
         dnsarp_pkg::PH_QFIXED: begin
            remain_in = remain_dec;
            if (remain_dec == 16'd0) next_rec = 1'b1;
         end
         // answer name
         dnsarp_pkg::PH_RNAME_LEN: begin
            if (req_packet_byte == 8'd0) begin
               phase_in  = dnsarp_pkg::PH_RFIXED;
               remain_in = dnsarp_pkg::RR_FIXED;
            end else if (is_ptr) begin
               phase_in = dnsarp_pkg::PH_RNAME_PTR;
            end else begin
               remain_in = {8'd0, req_packet_byte};
               phase_in  = dnsarp_pkg::PH_RNAME_SKIP;
            end
         end
         dnsarp_pkg::PH_RNAME_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == 16'd0) phase_in = dnsarp_pkg::PH_RNAME_LEN;
         end
         dnsarp_pkg::PH_RNAME_PTR: begin
            phase_in  = dnsarp_pkg::PH_RFIXED;
            remain_in = dnsarp_pkg::RR_FIXED;
         end
         // type, class, ttl, rdlength
         dnsarp_pkg::PH_RFIXED: begin
            if (fixed_idx == 16'd0 || fixed_idx == 16'd8) begin
               hold_in = req_packet_byte;
            end else if (fixed_idx == 16'd1) begin
               rtype_in = word_new;
            end else if (fixed_idx == 16'd9) begin
               rdlen_in = word_new;
            end
            remain_in = remain_dec;
            if (remain_dec == 16'd0) begin
               found_in = (rtype_in == dnsarp_pkg::RT_A && rdlen_in == 16'd4 &&
                           !query_type_ff) ||
                          (rtype_in == dnsarp_pkg::RT_AAAA && rdlen_in == 16'd16 &&
                           query_type_ff);
               if (rtype_in == dnsarp_pkg::RT_CNAME) begin
                  cname_seen_in = 1'b1;
                  cname_pos_in  = pos_plus[dnsarp_pkg::CNAME_W-1:0];
               end
               if (rdlen_in == 16'd0) begin
                  record_end = 1'b1;
               end else begin
                  remain_in = rdlen_in;
                  phase_in  = dnsarp_pkg::PH_RDATA;
               end
            end
         end
         // record data, captured when this is the address record
         dnsarp_pkg::PH_RDATA: begin
            if (found_ff) begin
               if (rtype_ff == dnsarp_pkg::RT_AAAA && remain_ff > 16'd8) begin
                  addr_hi_in = {addr_hi_ff[55:0], req_packet_byte};
               end else begin
                  addr_lo_in = {addr_lo_ff[55:0], req_packet_byte};
               end
            end
            remain_in = remain_dec;
            if (remain_dec == 16'd0) record_end = 1'b1;
         end
         dnsarp_pkg::PH_DONE: ;
         default: ;
      endcase

      // end of an answer record
      if (record_end) begin
         if (found_in) begin
            phase_in   = dnsarp_pkg::PH_DONE;
            outcome_in = (rtype_in == dnsarp_pkg::RT_A) ?
                         dnsarp_pkg::ST_A : dnsarp_pkg::ST_AAAA;
         end else begin
            answers_in = answers_ff - 16'd1;
            next_rec   = 1'b1;
         end
      end

      // move to the next answer or conclude
      if (next_rec) begin
         if (answers_in == 16'd0) begin
            phase_in   = dnsarp_pkg::PH_DONE;
            outcome_in = cname_seen_in ? dnsarp_pkg::ST_FOLLOW : dnsarp_pkg::ST_NOTFOUND;
         end else begin
            phase_in = dnsarp_pkg::PH_RNAME_LEN;
         end
      end

      // byte count saturates past the size limit
      if (offset_ff <= OFS_MAX) offset_in = pos_plus[OFS_W-1:0];
   end

   // result fields for the packet's last byte
   always_comb begin
      if (offset_in < OFS_HDR || offset_in > OFS_MAX) begin
         status_in = dnsarp_pkg::ST_DROP;
      end else if (phase_in == dnsarp_pkg::PH_DONE) begin
         status_in = outcome_in;
      end else begin
         status_in = dnsarp_pkg::ST_ERROR;
      end
      res_hi_in    = (status_in == dnsarp_pkg::ST_AAAA) ? addr_hi_in : 64'd0;
      res_lo_in    = 64'd0;
      if (status_in == dnsarp_pkg::ST_AAAA) begin
         res_lo_in = addr_lo_in;
      end else if (status_in == dnsarp_pkg::ST_A) begin
         res_lo_in = {32'd0, addr_lo_in[31:0]};
      end
      res_cname_in = (status_in == dnsarp_pkg::ST_FOLLOW) ?
                     cname_pos_in : {dnsarp_pkg::CNAME_W{1'b0}};
   end

   // parse state registers, cleared after every packet
   always_ff @(posedge clock) begin
      if (reset || load_result) begin
         phase_ff      <= dnsarp_pkg::PH_HEADER;
         offset_ff     <= '0;
         remain_ff     <= 16'd0;
         answers_ff    <= 16'd0;
         hold_ff       <= 8'd0;
         rtype_ff      <= 16'd0;
         rdlen_ff      <= 16'd0;
         found_ff      <= 1'b0;
         addr_hi_ff    <= 64'd0;
         addr_lo_ff    <= 64'd0;
         cname_seen_ff <= 1'b0;
         cname_pos_ff  <= '0;
         outcome_ff    <= 3'd0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         remain_ff     <= remain_in;
         answers_ff    <= answers_in;
         hold_ff       <= hold_in;
         rtype_ff      <= rtype_in;
         rdlen_ff      <= rdlen_in;
         found_ff      <= found_in;
         addr_hi_ff    <= addr_hi_in;
         addr_lo_ff    <= addr_lo_in;
         cname_seen_ff <= cname_seen_in;
         cname_pos_ff  <= cname_pos_in;
         outcome_ff    <= outcome_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_result) begin
         status_ff    <= status_in;
         res_hi_ff    <= res_hi_in;
         res_lo_ff    <= res_lo_in;
         res_cname_ff <= res_cname_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_address_high = res_hi_ff;
   assign rsp_address_low  = res_lo_ff;
   assign rsp_cname_offset = res_cname_ff;

endmodule

@@ design/dnsarp_checker.sv @@
// port-level checks for the dns answer record parser, bound to the top level
module dnsarp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_address_high,
   input logic [63:0] rsp_address_low,
   input logic [10:0] rsp_cname_offset
);

   // input side only backs up behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // a new result follows a last-byte transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte))
      else $error("result without a last byte");

   // address fields are zero unless an address was found
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != dnsarp_pkg::ST_A && rsp_status != dnsarp_pkg::ST_AAAA)
      |-> (rsp_address_high == 64'd0 && rsp_address_low == 64'd0))
      else $error("address present without a found status");

   // cname offset only reported for follow, status in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= dnsarp_pkg::ST_DROP &&
                     (rsp_status == dnsarp_pkg::ST_FOLLOW || rsp_cname_offset == 11'd0)))
      else $error("bad status or stray cname offset");

   // held result stays valid, with its status and low address stable
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                     $stable(rsp_address_low)))
      else $error("stalled result changed");

endmodule

bind dns_answer_record_parser dnsarp_checker u_dnsarp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_byte    (req_last_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_address_high (rsp_address_high),
   .rsp_address_low  (rsp_address_low),
   .rsp_cname_offset (rsp_cname_offset)
);

@@ tb/sv/dns_answer_record_parser_tb.sv @@
// self-checking testbench for the dns answer record parser
module dns_answer_record_parser_tb;
   import dnsarp_pkg::*;

   localparam int unsigned PKT_LIMIT   = 1536;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   localparam logic Q_A    = 1'b0;
   localparam logic Q_AAAA = 1'b1;

   // question name forms for the directed packets
   localparam logic [1:0] QF_LABELS  = 2'd0;
   localparam logic [1:0] QF_POINTER = 2'd1;
   localparam logic [1:0] QF_LONG    = 2'd2;

   localparam logic [15:0] RT_NONE  = 16'd0;
   localparam logic [15:0] RT_EMPTY = 16'h0010;
   localparam logic [15:0] RT_ODD   = 16'hFFFF;
   localparam logic [15:0] RT_MISC  = 16'h000F;

   // directed rdata bytes run 0xa0, 0xa1, ... so found addresses read off directly
   localparam logic [63:0] Z64    = 64'd0;
   localparam logic [63:0] A_WORD = 64'h0000_0000_A0A1_A2A3;
   localparam logic [63:0] V6_HI  = 64'hA0A1_A2A3_A4A5_A6A7;
   localparam logic [63:0] V6_LO  = 64'hA8A9_AAAB_ACAD_AEAF;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] high;
      logic [63:0] low;
      logic [10:0] cname;
   } verdict_t;

   typedef struct packed {
      logic [15:0] eid;
      logic        qt;
      logic [15:0] id;
      logic [7:0]  flags;
      logic [15:0] ancount;
      logic [1:0]  qform;
      logic [1:0]  nrec;
      logic [15:0] t0;
      logic [15:0] l0;
      logic [15:0] t1;
      logic [15:0] l1;
      logic [11:0] total;
      logic        typed;
      logic [2:0]  st;
      logic [63:0] hi;
      logic [63:0] lo;
   } probe_row;

   localparam int NUM_PROBES = 26;
   localparam probe_row PROBES [NUM_PROBES] = '{
      // plain A answer right after reset
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_A, Z64, A_WORD},
      // id mismatch
      '{16'h0000, Q_A, 16'h0001, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_DROP, Z64, Z64},
      // shorter than a header
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd11, 1'b1, ST_DROP, Z64, Z64},
      // header only, question missing
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd12, 1'b1, ST_ERROR, Z64, Z64},
      // nxdomain rcode
      '{16'h0000, Q_A, 16'h0000, 8'h83, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_NOTFOUND, Z64, Z64},
      // other rcode, all flag bits set
      '{16'h0000, Q_A, 16'h0000, 8'hFF, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_ERROR, Z64, Z64},
      // no answers
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd0, QF_LABELS, 2'd0, RT_NONE, 16'd0, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_NOTFOUND, Z64, Z64},
      // question name as a pointer
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_POINTER, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_A, Z64, A_WORD},
      // label length above 0x3f is still a label
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LONG, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_A, Z64, A_WORD},
      // cname only, follow
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_CNAME, 16'd6, RT_NONE, 16'd0,
        12'd0, 1'b0, ST_FOLLOW, Z64, Z64},
      // cname then A
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd2, QF_LABELS, 2'd2, RT_CNAME, 16'd6, RT_A, 16'd4,
        12'd0, 1'b1, ST_A, Z64, A_WORD},
      // A record with the wrong length
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd5, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_NOTFOUND, Z64, Z64},
      // AAAA while seeking A
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_AAAA, 16'd16, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_NOTFOUND, Z64, Z64},
      // empty rdata, then A
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd2, QF_LABELS, 2'd2, RT_EMPTY, 16'd0, RT_A, 16'd4,
        12'd0, 1'b1, ST_A, Z64, A_WORD},
      // cut inside the answer
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd30, 1'b1, ST_ERROR, Z64, Z64},
      // trailing bytes after the match
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd60, 1'b1, ST_A, Z64, A_WORD},
      // largest answer count
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'hFFFF, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_A, Z64, A_WORD},
      // packet ends between records
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd2, QF_LABELS, 2'd1, RT_ODD, 16'd3, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_ERROR, Z64, Z64},
      // cname followed by an unrelated record
      '{16'h0000, Q_A, 16'h0000, 8'h80, 16'd2, QF_POINTER, 2'd2, RT_CNAME, 16'd2, RT_MISC, 16'd3,
        12'd0, 1'b0, ST_FOLLOW, Z64, Z64},
      // AAAA query
      '{16'h0000, Q_AAAA, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_AAAA, 16'd16, RT_NONE,
        16'd0, 12'd0, 1'b1, ST_AAAA, V6_HI, V6_LO},
      '{16'h0000, Q_AAAA, 16'h0000, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_NOTFOUND, Z64, Z64},
      '{16'h0000, Q_AAAA, 16'h0000, 8'h80, 16'd2, QF_LABELS, 2'd2, RT_AAAA, 16'd4, RT_AAAA,
        16'd16, 12'd0, 1'b1, ST_AAAA, V6_HI, V6_LO},
      // all-ones id
      '{16'hFFFF, Q_AAAA, 16'hFFFF, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_AAAA, 16'd16, RT_NONE,
        16'd0, 12'd0, 1'b1, ST_AAAA, V6_HI, V6_LO},
      // largest legal packet
      '{16'hFFFF, Q_A, 16'hFFFF, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd1536, 1'b1, ST_A, Z64, A_WORD},
      // one byte too long
      '{16'hFFFF, Q_A, 16'hFFFF, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd1537, 1'b1, ST_DROP, Z64, Z64},
      // id off in the low byte only
      '{16'hFFFF, Q_A, 16'hFFFE, 8'h80, 16'd1, QF_LABELS, 2'd1, RT_A, 16'd4, RT_NONE, 16'd0,
        12'd0, 1'b1, ST_DROP, Z64, Z64}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_packet_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_address_high;
   logic [63:0] rsp_address_low;
   logic [10:0] rsp_cname_offset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dns_answer_record_parser dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // register copies
   logic [15:0] cfg_id;
   logic        cfg_aaaa;

   // parse state of the predictor
   phase_type   ph;
   int unsigned seen;
   logic [15:0] remain;
   logic [15:0] answers;
   logic [15:0] word;
   logic [15:0] rtype;
   logic [15:0] rdlen;
   bit          hit;
   logic [63:0] addr_hi;
   logic [63:0] addr_lo;
   bit          cname_seen;
   logic [10:0] cname_pos;
   logic [2:0]  outcome;

   verdict_t    pending_verdicts[$];
   verdict_t    scripted_verdict;
   bit          scripted_ready;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   bit          quiet;
   int unsigned stall_run;
   logic [7:0]  frame_bytes[$];

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function void clear_parse();
      ph = PH_HEADER;
      seen = 0;
      remain = '0;
      answers = '0;
      word = '0;
      rtype = '0;
      rdlen = '0;
      hit = 1'b0;
      addr_hi = '0;
      addr_lo = '0;
      cname_seen = 1'b0;
      cname_pos = '0;
      outcome = '0;
   endfunction

   function void settle(logic [2:0] code);
      ph = PH_DONE;
      outcome = code;
   endfunction

   function void next_answer();
      if (answers == 0) settle(cname_seen ? ST_FOLLOW : ST_NOTFOUND);
      else ph = PH_RNAME_LEN;
   endfunction

   function void close_record();
      if (hit) begin
         settle(rtype == RT_A ? ST_A : ST_AAAA);
      end else begin
         answers = answers - 16'd1;
         next_answer();
      end
   endfunction

   // one byte of a question or answer name
   function void name_step(logic [7:0] b, bit in_answer);
      case (ph)
         PH_QNAME_LEN, PH_RNAME_LEN: begin
            if (b == 8'd0) begin
               ph = in_answer ? PH_RFIXED : PH_QFIXED;
               remain = in_answer ? RR_FIXED : Q_FIXED;
            end else if ((b & PTR_MARK) == PTR_MARK) begin
               ph = in_answer ? PH_RNAME_PTR : PH_QNAME_PTR;
            end else begin
               remain = {8'd0, b};
               ph = in_answer ? PH_RNAME_SKIP : PH_QNAME_SKIP;
            end
         end
         PH_QNAME_SKIP, PH_RNAME_SKIP: begin
            remain = remain - 16'd1;
            if (remain == 0) ph = in_answer ? PH_RNAME_LEN : PH_QNAME_LEN;
         end
         default: begin
            ph = in_answer ? PH_RFIXED : PH_QFIXED;
            remain = in_answer ? RR_FIXED : Q_FIXED;
         end
      endcase
   endfunction

   // advance the predictor by one accepted byte, queue the verdict on the last one
   function void track_byte(logic [7:0] b, logic last);
      int unsigned pos;
      int unsigned idx;
      logic [2:0]  st;
      verdict_t    v;
      pos = seen;
      case (ph)
         PH_HEADER: begin
            case (pos)
               0, 6: word = {8'd0, b};
               1: begin
                  word = {word[7:0], b};
                  if (word != cfg_id) settle(ST_DROP);
               end
               3: begin
                  if (b[3:0] == RCODE_NXDOMAIN) settle(ST_NOTFOUND);
                  else if (b[3:0] != 4'd0) settle(ST_ERROR);
               end
               7: answers = {word[7:0], b};
               HDR_LEN - 1: ph = PH_QNAME_LEN;
               default: ;
            endcase
         end
         PH_QNAME_LEN, PH_QNAME_SKIP, PH_QNAME_PTR: name_step(b, 1'b0);
         PH_QFIXED: begin
            remain = remain - 16'd1;
            if (remain == 0) next_answer();
         end
         PH_RNAME_LEN, PH_RNAME_SKIP, PH_RNAME_PTR: name_step(b, 1'b1);
         PH_RFIXED: begin
            idx = RR_FIXED - remain;
            if (idx == 0 || idx == 8) word = {8'd0, b};
            else if (idx == 1) rtype = {word[7:0], b};
            else if (idx == 9) rdlen = {word[7:0], b};
            remain = remain - 16'd1;
            if (remain == 0) begin
               hit = (rtype == RT_A && rdlen == 16'd4 && cfg_aaaa == Q_A) ||
                     (rtype == RT_AAAA && rdlen == 16'd16 && cfg_aaaa == Q_AAAA);
               if (rtype == RT_CNAME) begin
                  cname_seen = 1'b1;
                  cname_pos = 11'(pos + 1);
               end
               if (rdlen == 0) begin
                  close_record();
               end else begin
                  remain = rdlen;
                  ph = PH_RDATA;
               end
            end
         end
         PH_RDATA: begin
            if (hit) begin
               idx = rdlen - remain;
               if (rtype == RT_AAAA && idx < 8) addr_hi = {addr_hi[55:0], b};
               else addr_lo = {addr_lo[55:0], b};
            end
            remain = remain - 16'd1;
            if (remain == 0) close_record();
         end
         default: ;
      endcase
      if (seen <= PKT_LIMIT) seen++;
      if (last) begin
         if (seen < HDR_LEN || seen > PKT_LIMIT) st = ST_DROP;
         else if (ph == PH_DONE) st = outcome;
         else st = ST_ERROR;
         v.status = st;
         v.high = (st == ST_AAAA) ? addr_hi : Z64;
         v.low = (st == ST_AAAA) ? addr_lo : (st == ST_A) ? {32'd0, addr_lo[31:0]} : Z64;
         v.cname = (st == ST_FOLLOW) ? cname_pos : 11'd0;
         if (scripted_ready) begin
            pending_verdicts.push_back(scripted_verdict);
            scripted_ready = 1'b0;
         end else begin
            pending_verdicts.push_back(v);
         end
         clear_parse();
      end
   endfunction

   task report_bad(string what, verdict_t want, verdict_t got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected status %0d high %h low %h cname %0d, got status %0d high %h low %h cname %0d",
                  what, want.status, want.high, want.low, want.cname,
                  got.status, got.high, got.low, got.cname);
   endtask

   // result check and byte tracking, sampled before the edge updates
   always @(posedge clock) begin
      verdict_t got;
      verdict_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_address_high, rsp_address_low, rsp_cname_offset};
            if (pending_verdicts.size() == 0) begin
               report_bad("result with no packet pending", '0, got);
            end else begin
               want = pending_verdicts.pop_front();
               if (got.status !== want.status || got.high !== want.high ||
                   got.low !== want.low || got.cname !== want.cname)
                  report_bad("result mismatch", want, got);
            end
         end
         if (req_valid && !req_stall) track_byte(req_packet_byte, req_last_byte);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_run == 0 && !quiet && $urandom_range(0, 3) == 0) stall_run = pick_gap();
      rsp_stall <= (stall_run != 0);
      if (stall_run != 0) stall_run--;
   end

   // one byte transaction, called at a falling edge, returns at a falling edge
   task push_byte(logic [7:0] b, logic last);
      int unsigned gap;
      gap = quiet ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_packet_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task send_frame();
      int k;
      quiet = ($urandom_range(0, 4) == 0);
      for (k = 0; k < frame_bytes.size(); k++)
         push_byte(frame_bytes[k], k == frame_bytes.size() - 1);
   endtask

   // wait until every result is out and the parser is back at rest
   task settle_idle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task write_reg(logic idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_EXPECTED_ID) cfg_id = value[15:0];
      else cfg_aaaa = value[0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function void put16(logic [15:0] v);
      frame_bytes.push_back(v[15:8]);
      frame_bytes.push_back(v[7:0]);
   endfunction

   function void put_fixed_record(logic [15:0] t, logic [15:0] l, bit labelled);
      int k;
      if (labelled) begin
         frame_bytes.push_back(8'd2);
         frame_bytes.push_back(8'h6E);
         frame_bytes.push_back(8'h73);
         frame_bytes.push_back(8'd0);
      end else begin
         put16(16'hC00C);
      end
      put16(t);
      put16(16'h0001);
      put16(16'h0000);
      put16(16'h0E10);
      put16(l);
      for (k = 0; k < l; k++) frame_bytes.push_back(8'hA0 + 8'(k));
   endfunction

   // lay out one directed packet
   function void build_probe(probe_row r);
      frame_bytes.delete();
      put16(r.id);
      frame_bytes.push_back(8'h81);
      frame_bytes.push_back(r.flags);
      put16(16'd1);
      put16(r.ancount);
      put16(16'd0);
      put16(16'd0);
      if (r.qform == QF_POINTER) begin
         put16(16'hC00C);
      end else if (r.qform == QF_LONG) begin
         frame_bytes.push_back(8'h80);
         repeat (128) frame_bytes.push_back(8'h61);
         frame_bytes.push_back(8'd0);
      end else begin
         frame_bytes.push_back(8'd3);
         frame_bytes.push_back(8'h61);
         frame_bytes.push_back(8'h62);
         frame_bytes.push_back(8'h63);
         frame_bytes.push_back(8'd0);
      end
      put16(RT_A);
      put16(16'h0001);
      if (r.nrec > 0) put_fixed_record(r.t0, r.l0, 1'b0);
      if (r.nrec > 1) put_fixed_record(r.t1, r.l1, 1'b1);
      if (r.total != 0) begin
         while (frame_bytes.size() > r.total) void'(frame_bytes.pop_back());
         while (frame_bytes.size() < r.total) frame_bytes.push_back(8'(frame_bytes.size()));
      end
   endfunction

   function void put_random_name();
      int unsigned len;
      if ($urandom_range(0, 3) == 0) begin
         frame_bytes.push_back({2'b11, 6'($urandom)});
         frame_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 70) : $urandom_range(1, 6);
            frame_bytes.push_back(8'(len));
            repeat (len) frame_bytes.push_back(8'($urandom));
         end
         frame_bytes.push_back(8'd0);
      end
   endfunction

   // mostly well-formed responses with random content, some broken or noise
   function void build_random();
      int unsigned shape;
      int unsigned k;
      int unsigned n;
      int unsigned cut;
      logic [15:0] t;
      logic [15:0] l;
      frame_bytes.delete();
      shape = $urandom_range(0, 99);
      if (shape < 4) begin
         repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
         return;
      end
      put16(($urandom_range(0, 9) == 0) ? 16'($urandom) : cfg_id);
      frame_bytes.push_back(8'($urandom));
      k = $urandom_range(0, 9);
      frame_bytes.push_back(k < 8 ? {4'($urandom), 4'd0} :
                            k == 8 ? {4'($urandom), RCODE_NXDOMAIN} : 8'($urandom));
      n = $urandom_range(0, 4);
      put16(16'($urandom));
      put16(($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)));
      put16(16'($urandom));
      put16(16'($urandom));
      put_random_name();
      put16(16'($urandom));
      put16(16'($urandom));
      repeat (n) begin
         put_random_name();
         k = $urandom_range(0, 9);
         if (k < 3) begin
            t = RT_A;
            l = ($urandom_range(0, 4) != 0) ? 16'd4 : 16'($urandom_range(0, 8));
         end else if (k < 6) begin
            t = RT_AAAA;
            l = ($urandom_range(0, 4) != 0) ? 16'd16 : 16'($urandom_range(0, 20));
         end else if (k < 8) begin
            t = RT_CNAME;
            l = 16'($urandom_range(2, 12));
         end else begin
            t = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            l = 16'($urandom_range(0, 10));
         end
         put16(t);
         put16(16'($urandom));
         put16(16'($urandom));
         put16(16'($urandom));
         put16(l);
         repeat (l) frame_bytes.push_back(8'($urandom));
      end
      if (shape < 12) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end else if (shape < 18) begin
         repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      end else if (shape < 19) begin
         cut = $urandom_range(PKT_LIMIT + 1, PKT_LIMIT + 24);
         while (frame_bytes.size() < cut) frame_bytes.push_back(8'($urandom));
      end
   endfunction

   // main sequence
   initial begin
      int i;
      int unsigned sent_bytes;
      int unsigned sent_frames;
      int unsigned pick;
      probe_row r;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_packet_byte = '0;
      req_last_byte = 1'b0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_id = '0;
      cfg_aaaa = Q_A;
      scripted_ready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      quiet = 1'b0;
      stall_run = 0;
      clear_parse();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed packets
      for (i = 0; i < NUM_PROBES; i++) begin
         r = PROBES[i];
         if (r.eid != cfg_id || r.qt != cfg_aaaa) begin
            settle_idle();
            if (r.eid != cfg_id) write_reg(REG_EXPECTED_ID, {16'($urandom), r.eid});
            if (r.qt != cfg_aaaa) write_reg(REG_QUERY_TYPE, {31'($urandom), r.qt});
         end
         build_probe(r);
         if (r.typed) begin
            scripted_verdict = {r.st, r.hi, r.lo, 11'd0};
            scripted_ready = 1'b1;
         end
         send_frame();
      end

      // random packets, registers reshuffled every few packets
      sent_bytes = 0;
      sent_frames = 0;
      while (sent_bytes < 550 || sent_frames < 40) begin
         if (sent_frames % 8 == 0) begin
            settle_idle();
            pick = $urandom_range(0, 5);
            write_reg(REG_EXPECTED_ID, {16'($urandom),
                      pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF : 16'($urandom)});
            write_reg(REG_QUERY_TYPE, 32'($urandom));
         end
         build_random();
         send_frame();
         sent_bytes += frame_bytes.size();
         sent_frames++;
      end

      // drain and report
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  pending_verdicts.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
